// ===== rtl/asgr_pkg.sv =====
`timescale 1ns / 1ps
// asgr_pkg: constants, result type and helper functions of the sgr escape parser
// no dependencies; used by ansi_sgr_escape_parser_unit
package asgr_pkg;

  // character codes
  localparam logic [7:0] CH_ESC      = 8'd27;
  localparam logic [7:0] CH_LBRACKET = 8'd91;
  localparam logic [7:0] CH_SEMI     = 8'd59;
  localparam logic [7:0] CH_ZERO     = 8'd48;
  localparam logic [7:0] CH_NINE     = 8'd57;
  localparam logic [7:0] CH_SGR_END  = 8'd109;

  // attribute layout: [2:0] colour, [3] bright, [4] invert
  localparam logic [4:0] ATTR_WHITE  = 5'd7;
  localparam logic [4:0] ATTR_BRIGHT = 5'd8;
  localparam logic [4:0] ATTR_INVERT = 5'd16;

  // parameter value ceiling and code ranges
  localparam logic [6:0] PARAM_MAX   = 7'd127;
  localparam logic [6:0] CODE_RESET  = 7'd0;
  localparam logic [6:0] CODE_BRIGHT = 7'd1;
  localparam logic [6:0] CODE_INVERT = 7'd7;
  localparam logic [6:0] CODE_FG_LO  = 7'd30;
  localparam logic [6:0] CODE_FG_HI  = 7'd37;
  localparam logic [6:0] CODE_HI_LO  = 7'd90;
  localparam logic [6:0] CODE_HI_HI  = 7'd97;

  // result queue depth
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  // one result
  typedef struct packed {
    logic       last_of_item;
    logic       end_of_line;
    logic       has_text;
    logic       segment_start;
    logic [4:0] attribute;
    logic [7:0] out_byte;
  } result_t;

  // letters that close a control sequence
  function automatic logic is_terminator(input logic [7:0] b);
    return b inside {"m", "A", "B", "C", "D", "E", "F", "G", "H", "J", "K",
                     "S", "T", "f", "i", "n", "k"};
  endfunction

  // apply one finished parameter to the working attribute
  function automatic logic [4:0] apply_param(input logic [6:0] pv,
                                             input logic       has_digit,
                                             input logic [4:0] a);
    logic [4:0] r;
    logic [6:0] d_fg;
    logic [6:0] d_hi;
    r    = a;
    d_fg = pv - CODE_FG_LO;
    d_hi = pv - CODE_HI_LO;
    if (has_digit) begin
      if (pv == CODE_RESET) begin
        r = ATTR_WHITE;
      end else if (pv == CODE_BRIGHT) begin
        r = a | ATTR_BRIGHT;
      end else if (pv == CODE_INVERT) begin
        r = a | ATTR_INVERT;
      end else if (pv >= CODE_FG_LO && pv <= CODE_FG_HI) begin
        r = {a[4:3], d_fg[2:0]};
      end else if (pv >= CODE_HI_LO && pv <= CODE_HI_HI) begin
        r = {a[4], 1'b1, d_hi[2:0]};
      end
    end
    return r;
  endfunction

  // next parameter value after one more decimal digit, saturating
  function automatic logic [6:0] add_digit(input logic [6:0] pv, input logic [7:0] b);
    logic [10:0] v;
    v = 11'(pv) * 11'd10 + 11'(b - CH_ZERO);
    return (v > 11'(PARAM_MAX)) ? PARAM_MAX : v[6:0];
  endfunction

endpackage

// ===== rtl/ansi_sgr_escape_parser_unit.sv =====
`timescale 1ns / 1ps
// ansi_sgr_escape_parser_unit: strips sgr escape sequences from a byte stream
// depends on asgr_pkg
//
// an accepted byte's results are registered in the result queue before they reach the output
// throughput: one byte per cycle while s_tready is high; a byte that yields two results (lone esc
//   followed by text) writes both into the queue, absorbed by a 4-entry result queue
// s_tready depends on registered queue occupancy only
// rst (synchronous) empties the queue and returns the parser to text mode, white
module ansi_sgr_escape_parser_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] text_byte
  input  logic        s_tlast,   // line_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] out_byte, [12:8] attribute, [13] segment_start,
                                 // [14] last_of_item, [15] zero
  output logic        m_tuser,   // has_text
  output logic        m_tlast    // end_of_line
);

  typedef enum logic [1:0] {
    MODE_TEXT = 2'd0,
    MODE_ESC  = 2'd1,
    MODE_SEQ  = 2'd2
  } mode_t;

  // parser state
  mode_t      mode;
  logic [4:0] cur_attr;
  logic [4:0] work_attr;
  logic [6:0] param_value;
  logic       param_has_digit;
  logic       param_closed;
  logic       seg_pending;

  mode_t      mode_next;
  logic [4:0] cur_attr_next;
  logic [4:0] work_attr_next;
  logic [6:0] param_value_next;
  logic       param_has_digit_next;
  logic       param_closed_next;
  logic       seg_pending_next;

  // results of the current byte
  asgr_pkg::result_t res0;
  asgr_pkg::result_t res1;
  logic [1:0]        res_cnt;

  // result queue
  asgr_pkg::result_t         q [asgr_pkg::QDEPTH];
  logic [asgr_pkg::QAW-1:0]  wr_ptr;
  logic [asgr_pkg::QAW-1:0]  rd_ptr;
  logic [asgr_pkg::QAW:0]    count;
  logic [asgr_pkg::QAW:0]    count_next;

  logic in_take;
  logic out_take;
  logic [7:0] b;
  logic       eol;
  logic       esc_prefix;
  logic       main_emit;
  logic [4:0] applied;
  logic [1:0] text_cnt;

  assign b        = s_tdata;
  assign eol      = s_tlast;
  assign s_tready = (count <= (asgr_pkg::QAW + 1)'(asgr_pkg::QDEPTH - 2));
  assign in_take  = s_tvalid && s_tready;
  assign m_tvalid = (count != '0);
  assign out_take = m_tvalid && m_tready;
  assign applied  = asgr_pkg::apply_param(param_value, param_has_digit, work_attr);

  // per-byte parse and result build
  always_comb begin
    asgr_pkg::result_t first;
    asgr_pkg::result_t second;
    first                = '0;
    second               = '0;
    mode_next            = mode;
    cur_attr_next        = cur_attr;
    work_attr_next       = work_attr;
    param_value_next     = param_value;
    param_has_digit_next = param_has_digit;
    param_closed_next    = param_closed;
    seg_pending_next     = seg_pending;
    esc_prefix           = 1'b0;
    main_emit            = 1'b0;

    if (mode == MODE_SEQ) begin
      // inside a control sequence
      if (asgr_pkg::is_terminator(b)) begin
        if (b == asgr_pkg::CH_SGR_END) begin
          cur_attr_next = applied;
        end
        work_attr_next       = applied;
        param_value_next     = '0;
        param_has_digit_next = 1'b0;
        param_closed_next    = 1'b0;
        mode_next            = MODE_TEXT;
        seg_pending_next     = 1'b1;
      end else if (b == asgr_pkg::CH_SEMI) begin
        work_attr_next       = applied;
        param_value_next     = '0;
        param_has_digit_next = 1'b0;
        param_closed_next    = 1'b0;
      end else if (b >= asgr_pkg::CH_ZERO && b <= asgr_pkg::CH_NINE) begin
        if (!param_closed) begin
          param_value_next     = asgr_pkg::add_digit(param_value, b);
          param_has_digit_next = 1'b1;
        end
      end else begin
        param_closed_next = 1'b1;
      end
    end else if (mode == MODE_ESC && b == asgr_pkg::CH_LBRACKET) begin
      // sequence opens
      mode_next            = MODE_SEQ;
      work_attr_next       = cur_attr;
      param_value_next     = '0;
      param_has_digit_next = 1'b0;
      param_closed_next    = 1'b0;
    end else begin
      // text path, possibly with a held esc emitted first
      esc_prefix = (mode == MODE_ESC);
      if (b == asgr_pkg::CH_ESC) begin
        main_emit = eol;
        mode_next = eol ? MODE_TEXT : MODE_ESC;
      end else begin
        main_emit = 1'b1;
        mode_next = MODE_TEXT;
      end
      if (esc_prefix || main_emit) begin
        seg_pending_next = 1'b0;
      end
    end

    text_cnt = {1'b0, esc_prefix} + {1'b0, main_emit};

    first.out_byte      = esc_prefix ? asgr_pkg::CH_ESC : b;
    first.attribute     = cur_attr;
    first.segment_start = seg_pending;
    first.has_text      = 1'b1;
    second.out_byte     = b;
    second.attribute    = cur_attr;
    second.has_text     = 1'b1;

    // bare line-end marker when nothing else is emitted
    if (text_cnt == 2'd0) begin
      first = '0;
    end

    if (text_cnt == 2'd2) begin
      second.last_of_item = 1'b1;
      second.end_of_line  = eol;
    end else begin
      first.last_of_item = 1'b1;
      first.end_of_line  = eol;
    end

    res0 = first;
    res1 = second;
    if (text_cnt != 2'd0) begin
      res_cnt = text_cnt;
    end else begin
      res_cnt = eol ? 2'd1 : 2'd0;
    end

    // line end returns everything to its start values
    if (eol) begin
      mode_next            = MODE_TEXT;
      cur_attr_next        = asgr_pkg::ATTR_WHITE;
      work_attr_next       = asgr_pkg::ATTR_WHITE;
      param_value_next     = '0;
      param_has_digit_next = 1'b0;
      param_closed_next    = 1'b0;
      seg_pending_next     = 1'b1;
    end
  end

  // parser state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= MODE_TEXT;
      cur_attr        <= asgr_pkg::ATTR_WHITE;
      work_attr       <= asgr_pkg::ATTR_WHITE;
      param_value     <= '0;
      param_has_digit <= 1'b0;
      param_closed    <= 1'b0;
      seg_pending     <= 1'b1;
    end else if (in_take) begin
      mode            <= mode_next;
      cur_attr        <= cur_attr_next;
      work_attr       <= work_attr_next;
      param_value     <= param_value_next;
      param_has_digit <= param_has_digit_next;
      param_closed    <= param_closed_next;
      seg_pending     <= seg_pending_next;
    end
  end

  // queue occupancy
  always_comb begin
    count_next = count;
    if (in_take) begin
      count_next = count_next + (asgr_pkg::QAW + 1)'(res_cnt);
    end
    if (out_take) begin
      count_next = count_next - 1'b1;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (in_take) begin
        wr_ptr <= wr_ptr + asgr_pkg::QAW'(res_cnt);
      end
      if (out_take) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (in_take && res_cnt != 2'd0) begin
      q[wr_ptr] <= res0;
      if (res_cnt == 2'd2) begin
        q[wr_ptr + 1'b1] <= res1;
      end
    end
  end

  // output transaction fields
  always_comb begin
    asgr_pkg::result_t head;
    head    = q[rd_ptr];
    m_tdata = {1'b0, head.last_of_item, head.segment_start, head.attribute, head.out_byte};
    m_tuser = head.has_text;
    m_tlast = head.end_of_line;
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (asgr_pkg::QAW + 1)'(asgr_pkg::QDEPTH))
    else $error("result queue overflow");

  a_eol_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata[14])
    else $error("end of line on a result that is not last of its byte");

  a_marker_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> (m_tdata[13:0] == '0) && m_tlast)
    else $error("bare marker carries text fields");

  a_line_reset: assert property (@(posedge clk) disable iff (rst)
    in_take && s_tlast |=> mode == MODE_TEXT && seg_pending &&
                           cur_attr == asgr_pkg::ATTR_WHITE)
    else $error("parser not back at line start after line end");

  a_seq_no_text: assert property (@(posedge clk) disable iff (rst)
    in_take && mode == MODE_SEQ && !s_tlast |-> res_cnt == 2'd0)
    else $error("text emitted from inside a control sequence");

endmodule
